// ===== src/kdef_pkg.sv =====
// Shared types, constants and helpers of the key debounce event FIFO.
package kdef_pkg;

    localparam int KEY_TOTAL  = 6;
    localparam int FIFO_DEPTH = 16;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

    localparam int FILTER_W = 7;
    localparam int DB_W     = FILTER_W + 1;
    localparam int LONG_W   = 16;
    localparam int REP_W    = 8;
    localparam int TIMING_W = LONG_W + REP_W;
    localparam int CODE_W   = 8;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = TIMING_W;

    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_TIME   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_LEVELS = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_KEY0_TIMING   = CFG_IDX_W'(2);

    localparam logic [FILTER_W-1:0]  FILTER_RESET = FILTER_W'(5);
    localparam logic [KEY_TOTAL-1:0] LEVELS_RESET = KEY_TOTAL'(1);
    localparam logic [DB_W-1:0]      DB_RESET     = DB_W'(FILTER_RESET / 2);
    // key 5 first, key 0 last
    localparam logic [KEY_TOTAL-1:0][TIMING_W-1:0] TIMING_RESET = {
        24'd25600, 24'd25606, 24'd25606, 24'd25606, 24'd25606, 24'd25600
    };

    // Event slots per key, in the order they are written to the FIFO.
    localparam int EV_PRESS   = 0;
    localparam int EV_LONG    = 1;
    localparam int EV_REPEAT  = 2;
    localparam int EV_RELEASE = 3;
    localparam int EV_KINDS   = 4;
    localparam int MASK_W     = KEY_TOTAL * EV_KINDS;
    localparam int SLOT_W     = $clog2(MASK_W);

    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
    localparam int RES_DEPTH  = 2;
    localparam int RES_PTR_W  = $clog2(RES_DEPTH);

    typedef enum logic [1:0] {
        ACT_SCAN  = 2'd0,
        ACT_POP   = 2'd1,
        ACT_CLEAR = 2'd2,
        ACT_PUSH  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_POP
    } t_back_state;

    typedef struct packed {
        t_action              action;
        logic [KEY_TOTAL-1:0] pin_levels;
        logic [CODE_W-1:0]    push_code;
    } t_in_item;

    typedef struct packed {
        logic [CODE_W-1:0]    event_code;
        logic [KEY_TOTAL-1:0] pressed_flags;
    } t_out_item;

    // Classified item handed from the scanner to the FIFO engine.
    typedef struct packed {
        t_action              action;
        logic [CODE_W-1:0]    push_code;
        logic [MASK_W-1:0]    ev_mask;
        logic [KEY_TOTAL-1:0] flags;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd head;
    } t_cmdq_stat;

    // Key k: press/repeat 3k+1, release 3k+2, long press 3k+3.
    function automatic logic [CODE_W-1:0] ev_code(input logic [SLOT_W-1:0] slot);
        logic [CODE_W-1:0] key;
        logic [CODE_W-1:0] off;
        key = CODE_W'(slot / EV_KINDS);
        case (int'(slot % EV_KINDS))
            EV_PRESS:   off = CODE_W'(1);
            EV_LONG:    off = CODE_W'(3);
            EV_REPEAT:  off = CODE_W'(1);
            EV_RELEASE: off = CODE_W'(2);
            default:    off = '0;
        endcase
        return (key << 1) + key + off;
    endfunction

endpackage

// ===== src/key_debounce_event_fifo.sv =====
// Top level of the six-key debounce scanner with its event FIFO.
//
// Input side is a queue: an item transfers when push is high and full is low.
// Each item carries an action (scan tick, pop event, clear FIFO, push code),
// the raw pin levels and a code to push. Every item yields exactly one result,
// read queue-style: while empty is low the oldest result sits on o_result and
// it transfers when pop is high.
// Config writes transfer on i_cfg_valid (o_cfg_ready is always high) and must
// only be issued while the block is idle; the block itself does not enforce it.
// The scanner updates all key state in the transfer cycle, so a new item can
// follow every cycle until the two-entry command queue fills. The FIFO engine
// behind it writes one event per cycle into the ring RAM: a scan item with
// events steps through ST_SCAN, a pop of a non-empty FIFO through ST_POP
// (registered RAM read); clear, push, empty pops and scans with no events
// finish in ST_IDLE. Each result is held in the result buffer until popped.
// A stalled receiver fills the two-entry result buffer, then the engine
// holds, then the command queue backs up and full rises.
// Synchronous reset restores the register defaults, sets every debounce
// counter to half the default filter time and empties all queues; the ring
// RAM is not cleared.
module key_debounce_event_fifo (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             push,
    output logic                             full,
    input  kdef_pkg::t_in_item               i_item,
    output logic                             empty,
    input  logic                             pop,
    output kdef_pkg::t_out_item              o_result,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [kdef_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [kdef_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import kdef_pkg::*;

    logic       accept;
    logic       q_pop;
    t_cmd       cmd;
    t_cmdq_stat q_stat;

    assign accept      = push && !full;
    assign o_cfg_ready = 1'b1;

    kdef_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_item      (i_item),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cmd       (cmd)
    );

    kdef_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_cmd   (cmd),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_stat  (q_stat)
    );

    kdef_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q      (q_stat),
        .o_q_pop  (q_pop),
        .o_empty  (empty),
        .i_pop    (pop),
        .o_result (o_result)
    );

    // engine never takes from an empty command queue
    a_qpop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_stat.valid)
        else $error("command queue popped while empty");

    // only scan ticks produce key events
    a_events_scan_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_item.action != ACT_SCAN) |-> (cmd.ev_mask == '0))
        else $error("key events from a non-scan item");

    // a non-scan item leaves the debounced flags unchanged
    a_flags_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_item.action != ACT_SCAN) |=>
            $stable(cmd.flags) || (i_item.action == ACT_SCAN && $past(accept)))
        else $error("pressed flags moved without a scan tick");
endmodule

// ===== src/kdef_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module kdef_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== src/kdef_front.sv =====
// Key scanner: config registers, per-key debounce/long/repeat state, event classification.
module kdef_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_accept,
    input  kdef_pkg::t_in_item                i_item,
    input  logic                              i_cfg_we,
    input  logic [kdef_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [kdef_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output kdef_pkg::t_cmd                    o_cmd
);
    import kdef_pkg::*;

    logic [FILTER_W-1:0]  r_filter;
    logic [KEY_TOTAL-1:0] r_levels;
    logic [TIMING_W-1:0]  r_timing [KEY_TOTAL];

    logic [DB_W-1:0]      r_db   [KEY_TOTAL];
    logic [DB_W-1:0]      n_db   [KEY_TOTAL];
    logic [KEY_TOTAL-1:0] r_pressed;
    logic [KEY_TOTAL-1:0] n_pressed;
    logic [LONG_W-1:0]    r_long [KEY_TOTAL];
    logic [LONG_W-1:0]    n_long [KEY_TOTAL];
    logic [REP_W-1:0]     r_rep  [KEY_TOTAL];
    logic [REP_W-1:0]     n_rep  [KEY_TOTAL];

    logic [KEY_TOTAL-1:0] active;
    logic                 sole;
    logic                 scan;
    logic [MASK_W-1:0]    ev;
    logic [DB_W-1:0]      ft1;
    logic [DB_W-1:0]      ft2;

    assign active = ~(i_item.pin_levels ^ r_levels);
    // exactly one active pin
    assign sole   = (active != '0) && ((active & (active - KEY_TOTAL'(1))) == '0);
    assign scan   = i_accept && (i_item.action == ACT_SCAN);
    assign ft1    = {1'b0, r_filter};
    assign ft2    = {r_filter, 1'b0};

    always_comb begin
        logic [LONG_W-1:0] lt;
        logic [REP_W-1:0]  rs;
        logic [LONG_W-1:0] lc_inc;
        logic [REP_W-1:0]  rc_inc;
        ev        = '0;
        n_pressed = r_pressed;
        for (int k = 0; k < KEY_TOTAL; k++) begin
            n_db[k]   = r_db[k];
            n_long[k] = r_long[k];
            n_rep[k]  = r_rep[k];
            lt        = r_timing[k][TIMING_W-1:REP_W];
            rs        = r_timing[k][REP_W-1:0];
            lc_inc    = r_long[k] + LONG_W'(1);
            rc_inc    = r_rep[k] + REP_W'(1);
            if (scan) begin
                if (sole && active[k]) begin
                    if (r_db[k] < ft1) begin
                        n_db[k] = ft1;
                    end else if (r_db[k] < ft2) begin
                        n_db[k] = r_db[k] + DB_W'(1);
                    end else begin
                        if (!r_pressed[k]) begin
                            n_pressed[k]              = 1'b1;
                            ev[k*EV_KINDS + EV_PRESS] = 1'b1;
                        end
                        if (lt != '0) begin
                            if (r_long[k] < lt) begin
                                n_long[k] = lc_inc;
                                ev[k*EV_KINDS + EV_LONG] = (lc_inc == lt);
                            end else if (rs != '0) begin
                                if (rc_inc >= rs) begin
                                    n_rep[k] = '0;
                                    ev[k*EV_KINDS + EV_REPEAT] = 1'b1;
                                end else begin
                                    n_rep[k] = rc_inc;
                                end
                            end
                        end
                    end
                end else begin
                    if (r_db[k] > ft1) begin
                        n_db[k] = ft1;
                    end else if (r_db[k] != '0) begin
                        n_db[k] = r_db[k] - DB_W'(1);
                    end else if (r_pressed[k]) begin
                        n_pressed[k]                = 1'b0;
                        ev[k*EV_KINDS + EV_RELEASE] = 1'b1;
                    end
                    n_long[k] = '0;
                    n_rep[k]  = '0;
                end
            end
            // a timing write restarts that key's repeat count
            if (i_cfg_we && (i_cfg_index == CFG_KEY0_TIMING + CFG_IDX_W'(k))) begin
                n_rep[k] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filter  <= FILTER_RESET;
            r_levels  <= LEVELS_RESET;
            r_pressed <= '0;
            for (int k = 0; k < KEY_TOTAL; k++) begin
                r_timing[k] <= TIMING_RESET[k];
                r_db[k]     <= DB_RESET;
                r_long[k]   <= '0;
                r_rep[k]    <= '0;
            end
        end else begin
            r_pressed <= n_pressed;
            for (int k = 0; k < KEY_TOTAL; k++) begin
                r_db[k]   <= n_db[k];
                r_long[k] <= n_long[k];
                r_rep[k]  <= n_rep[k];
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_FILTER_TIME:   r_filter <= i_cfg_data[FILTER_W-1:0];
                    CFG_ACTIVE_LEVELS: r_levels <= i_cfg_data[KEY_TOTAL-1:0];
                    default: begin
                        for (int k = 0; k < KEY_TOTAL; k++) begin
                            if (i_cfg_index == CFG_KEY0_TIMING + CFG_IDX_W'(k)) begin
                                r_timing[k] <= i_cfg_data[TIMING_W-1:0];
                            end
                        end
                    end
                endcase
            end
        end
    end

    always_comb begin
        o_cmd.action    = i_item.action;
        o_cmd.push_code = i_item.push_code;
        o_cmd.ev_mask   = ev;
        o_cmd.flags     = n_pressed;
    end
endmodule

// ===== src/kdef_cmd_queue.sv =====
// Two-entry queue of classified items between scanner and FIFO engine.
module kdef_cmd_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  kdef_pkg::t_cmd       i_cmd,
    output logic                 o_full,
    input  logic                 i_pop,
    output kdef_pkg::t_cmdq_stat o_stat
);
    import kdef_pkg::*;

    t_cmd                  r_mem [CMDQ_DEPTH];
    logic [CMDQ_PTR_W-1:0] r_wr;
    logic [CMDQ_PTR_W-1:0] r_rd;
    logic [CMDQ_PTR_W:0]   r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + CMDQ_PTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + CMDQ_PTR_W'(1);
            end
            r_cnt <= r_cnt + (CMDQ_PTR_W+1)'(i_push) - (CMDQ_PTR_W+1)'(i_pop);
        end
    end

    assign o_full       = (r_cnt == (CMDQ_PTR_W+1)'(CMDQ_DEPTH));
    assign o_stat.valid = (r_cnt != '0);
    assign o_stat.head  = r_mem[r_rd];
endmodule

// ===== src/kdef_back.sv =====
// FIFO engine: event ring buffer, pointer updates, result buffer.
module kdef_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  kdef_pkg::t_cmdq_stat i_q,
    output logic                 o_q_pop,
    output logic                 o_empty,
    input  logic                 i_pop,
    output kdef_pkg::t_out_item  o_result
);
    import kdef_pkg::*;

    t_back_state           r_state;
    t_back_state           n_state;
    logic [FIFO_PTR_W-1:0] r_rp;
    logic [FIFO_PTR_W-1:0] n_rp;
    logic [FIFO_PTR_W-1:0] r_wp;
    logic [FIFO_PTR_W-1:0] n_wp;
    logic [MASK_W-1:0]     r_mask;
    logic [MASK_W-1:0]     n_mask;
    logic [KEY_TOTAL-1:0]  r_flags;
    logic [KEY_TOTAL-1:0]  n_flags;

    logic                  we;
    logic [CODE_W-1:0]     wdata;
    logic                  re;
    logic [CODE_W-1:0]     rdata;
    logic [SLOT_W-1:0]     sel;

    t_out_item             r_res [RES_DEPTH];
    logic [RES_PTR_W-1:0]  r_res_wr;
    logic [RES_PTR_W-1:0]  r_res_rd;
    logic [RES_PTR_W:0]    r_res_cnt;
    logic                  room;
    logic                  res_push;
    logic                  res_pop;
    t_out_item             res_data;
    logic                  fifo_empty;

    assign room       = (r_res_cnt != (RES_PTR_W+1)'(RES_DEPTH));
    assign res_pop    = i_pop && (r_res_cnt != '0);
    assign fifo_empty = (r_rp == r_wp);

    // lowest pending event goes first
    always_comb begin
        sel = '0;
        for (int s = MASK_W - 1; s >= 0; s--) begin
            if (r_mask[s]) begin
                sel = SLOT_W'(s);
            end
        end
    end

    kdef_ram #(
        .WIDTH (CODE_W),
        .DEPTH (FIFO_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_wp),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (r_rp),
        .o_rdata (rdata)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_q.valid) begin
                    if (i_q.head.action == ACT_SCAN && i_q.head.ev_mask != '0) begin
                        n_state = ST_SCAN;
                    end else if (i_q.head.action == ACT_POP && room && !fifo_empty) begin
                        n_state = ST_POP;
                    end
                end
            end
            ST_SCAN: begin
                if (r_mask == '0 && room) begin
                    n_state = ST_IDLE;
                end
            end
            ST_POP: begin
                if (room) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_q_pop  = 1'b0;
        we       = 1'b0;
        wdata    = '0;
        re       = 1'b0;
        res_push = 1'b0;
        res_data = '0;
        n_rp     = r_rp;
        n_wp     = r_wp;
        n_mask   = r_mask;
        n_flags  = r_flags;
        case (r_state)
            ST_IDLE: begin
                if (i_q.valid) begin
                    case (i_q.head.action)
                        ACT_SCAN: begin
                            if (i_q.head.ev_mask != '0) begin
                                o_q_pop = 1'b1;
                                n_mask  = i_q.head.ev_mask;
                                n_flags = i_q.head.flags;
                            end else if (room) begin
                                o_q_pop                = 1'b1;
                                res_push               = 1'b1;
                                res_data.pressed_flags = i_q.head.flags;
                            end
                        end
                        ACT_POP: begin
                            if (room) begin
                                o_q_pop = 1'b1;
                                n_flags = i_q.head.flags;
                                if (fifo_empty) begin
                                    res_push               = 1'b1;
                                    res_data.pressed_flags = i_q.head.flags;
                                end else begin
                                    re   = 1'b1;
                                    n_rp = r_rp + FIFO_PTR_W'(1);
                                end
                            end
                        end
                        ACT_CLEAR: begin
                            if (room) begin
                                o_q_pop                = 1'b1;
                                n_rp                   = r_wp;
                                res_push               = 1'b1;
                                res_data.pressed_flags = i_q.head.flags;
                            end
                        end
                        ACT_PUSH: begin
                            if (room) begin
                                o_q_pop                = 1'b1;
                                we                     = 1'b1;
                                wdata                  = i_q.head.push_code;
                                n_wp                   = r_wp + FIFO_PTR_W'(1);
                                res_push               = 1'b1;
                                res_data.pressed_flags = i_q.head.flags;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_SCAN: begin
                if (r_mask == '0) begin
                    if (room) begin
                        res_push               = 1'b1;
                        res_data.pressed_flags = r_flags;
                    end
                end else begin
                    we     = 1'b1;
                    wdata  = ev_code(sel);
                    n_wp   = r_wp + FIFO_PTR_W'(1);
                    n_mask = r_mask & (r_mask - MASK_W'(1));
                end
            end
            ST_POP: begin
                if (room) begin
                    res_push               = 1'b1;
                    res_data.event_code    = rdata;
                    res_data.pressed_flags = r_flags;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (res_push) begin
            r_res[r_res_wr] <= res_data;
        end
        r_mask  <= n_mask;
        r_flags <= n_flags;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_rp      <= '0;
            r_wp      <= '0;
            r_res_wr  <= '0;
            r_res_rd  <= '0;
            r_res_cnt <= '0;
        end else begin
            r_state <= n_state;
            r_rp    <= n_rp;
            r_wp    <= n_wp;
            if (res_push) begin
                r_res_wr <= r_res_wr + RES_PTR_W'(1);
            end
            if (res_pop) begin
                r_res_rd <= r_res_rd + RES_PTR_W'(1);
            end
            r_res_cnt <= r_res_cnt + (RES_PTR_W+1)'(res_push) - (RES_PTR_W+1)'(res_pop);
        end
    end

    assign o_empty  = (r_res_cnt == '0);
    assign o_result = r_res[r_res_rd];
endmodule

// ===== sim/key_debounce_event_fifo_tb.sv =====
// Self-checking testbench of the key debounce scanner with its event FIFO.
`timescale 1ns / 100ps

module key_debounce_event_fifo_tb;
    import kdef_pkg::*;

    // Event code offsets within a key's group of three codes.
    localparam int PRESS_OFS   = 1;
    localparam int RELEASE_OFS = 2;
    localparam int LONG_OFS    = 3;

    // Register indexes past the last key timing register decode to nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = CFG_KEY0_TIMING + CFG_IDX_W'(KEY_TOTAL);
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = '1;

    // One row of the directed script: a register write or an input item,
    // the latter optionally with a result typed in by hand.
    typedef struct {
        bit                    is_reg;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        t_in_item              item;
        bit                    typed;
        t_out_item             want;
    } t_script_row;

    logic                  i_clk;
    logic                  i_rst_n     = 1'b0;
    logic                  push        = 1'b0;
    logic                  full;
    t_in_item              i_item      = '0;
    logic                  empty;
    logic                  pop         = 1'b0;
    t_out_item             o_result;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    key_debounce_event_fifo dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_item      (i_item),
        .empty       (empty),
        .pop         (pop),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop in case a handshake never completes.
    initial begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

    // ------------------------------------------------------------------
    // Shadow of the scanner: registers, per-key state and the event ring.
    // ------------------------------------------------------------------
    logic [FILTER_W-1:0]   filt;
    logic [KEY_TOTAL-1:0]  levels;
    logic [TIMING_W-1:0]   timing   [KEY_TOTAL];
    logic [DB_W-1:0]       db_cnt   [KEY_TOTAL];
    logic [KEY_TOTAL-1:0]  held;
    logic [LONG_W-1:0]     long_cnt [KEY_TOTAL];
    logic [REP_W-1:0]      rep_cnt  [KEY_TOTAL];
    logic [CODE_W-1:0]     ring     [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] rd_ptr;
    logic [FIFO_PTR_W-1:0] wr_ptr;

    t_out_item   awaited_readouts [$];   // expected results, oldest first
    t_script_row script [$];
    int          fail_count = 0;
    int          sent_items = 0;
    int          readouts   = 0;
    bit          steady_run = 1'b0;      // both sides stop idling while set

    function automatic void reset_shadow();
        filt   = FILTER_W'(5);
        levels = KEY_TOTAL'(1);
        for (int k = 0; k < KEY_TOTAL; k++) begin
            // keys 0 and 5: long press 100, no repeat; the rest repeat every 6
            timing[k]   = (k == 0 || k == KEY_TOTAL - 1) ? TIMING_W'(25600)
                                                         : TIMING_W'(25606);
            db_cnt[k]   = DB_W'(2);
            long_cnt[k] = '0;
            rep_cnt[k]  = '0;
        end
        held = '0;
        for (int i = 0; i < FIFO_DEPTH; i++) ring[i] = '0;
        rd_ptr = '0;
        wr_ptr = '0;
    endfunction

    function automatic void store_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] val);
        int k;
        k = int'(idx) - int'(CFG_KEY0_TIMING);
        if (idx == CFG_FILTER_TIME) begin
            filt = val[FILTER_W-1:0];
        end else if (idx == CFG_ACTIVE_LEVELS) begin
            levels = val[KEY_TOTAL-1:0];
        end else if (k >= 0 && k < KEY_TOTAL) begin
            // a timing write also restarts that key's repeat count
            timing[k]  = val[TIMING_W-1:0];
            rep_cnt[k] = '0;
        end
    endfunction

    function automatic logic [CODE_W-1:0] key_code(input int k, input int ofs);
        return CODE_W'(3 * k + ofs);
    endfunction

    // No full check: the write pointer wraps over unread codes.
    function automatic void post_event(input logic [CODE_W-1:0] code);
        ring[wr_ptr] = code;
        wr_ptr       = wr_ptr + 1'b1;
    endfunction

    function automatic logic [CODE_W-1:0] take_event();
        logic [CODE_W-1:0] code;
        if (rd_ptr == wr_ptr) return '0;
        code   = ring[rd_ptr];
        rd_ptr = rd_ptr + 1'b1;
        return code;
    endfunction

    function automatic void step_key(input int k, input bit down);
        int                ft;
        logic [LONG_W-1:0] long_time;
        logic [REP_W-1:0]  rep_period;
        ft         = int'(filt);
        long_time  = timing[k][TIMING_W-1:REP_W];
        rep_period = timing[k][REP_W-1:0];
        if (down) begin
            if (int'(db_cnt[k]) < ft) begin
                db_cnt[k] = DB_W'(ft);
            end else if (int'(db_cnt[k]) < 2 * ft) begin
                db_cnt[k] = db_cnt[k] + 1'b1;
            end else begin
                if (!held[k]) begin
                    held[k] = 1'b1;
                    post_event(key_code(k, PRESS_OFS));
                end
                if (long_time != '0) begin
                    if (long_cnt[k] < long_time) begin
                        long_cnt[k] = long_cnt[k] + 1'b1;
                        if (long_cnt[k] == long_time) post_event(key_code(k, LONG_OFS));
                    end else if (rep_period != '0) begin
                        rep_cnt[k] = rep_cnt[k] + 1'b1;
                        if (rep_cnt[k] >= rep_period) begin
                            rep_cnt[k] = '0;
                            post_event(key_code(k, PRESS_OFS));
                        end
                    end
                end
            end
        end else begin
            if (int'(db_cnt[k]) > ft) begin
                db_cnt[k] = DB_W'(ft);
            end else if (db_cnt[k] != '0) begin
                db_cnt[k] = db_cnt[k] - 1'b1;
            end else if (held[k]) begin
                held[k] = 1'b0;
                post_event(key_code(k, RELEASE_OFS));
            end
            long_cnt[k] = '0;
            rep_cnt[k]  = '0;
        end
    endfunction

    // A key is down only when its pin is the one active pin of all keys.
    function automatic void scan_keys(input logic [KEY_TOTAL-1:0] pins);
        int hits;
        int sole;
        hits = 0;
        sole = KEY_TOTAL;
        for (int k = 0; k < KEY_TOTAL; k++) begin
            if (pins[k] == levels[k]) begin
                hits++;
                sole = k;
            end
        end
        for (int k = 0; k < KEY_TOTAL; k++) step_key(k, hits == 1 && sole == k);
    endfunction

    // Result of one item: popped code (0 unless a pop finds a code) and flags.
    function automatic t_out_item apply_key_item(input t_in_item it);
        t_out_item res;
        res.event_code = '0;
        case (it.action)
            ACT_SCAN:  scan_keys(it.pin_levels);
            ACT_POP:   res.event_code = take_event();
            ACT_CLEAR: rd_ptr = wr_ptr;
            ACT_PUSH:  post_event(it.push_code);
            default:   ;
        endcase
        res.pressed_flags = held;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------
    task automatic note_mismatch(input string what);
        $display("mismatch at result %0d: %s", readouts, what);
        fail_count++;
    endtask

    task automatic check_readout(input t_out_item got);
        t_out_item want;
        if (awaited_readouts.size() == 0) begin
            note_mismatch($sformatf("no result expected, got code %0d flags %b",
                                    got.event_code, got.pressed_flags));
            return;
        end
        want = awaited_readouts.pop_front();
        if (got.event_code !== want.event_code)
            note_mismatch($sformatf("event_code %0d, expected %0d",
                                    got.event_code, want.event_code));
        if (got.pressed_flags !== want.pressed_flags)
            note_mismatch($sformatf("pressed_flags %b, expected %b",
                                    got.pressed_flags, want.pressed_flags));
    endtask

    // Receiver: samples on the edge, then decides pop for the next edge.
    initial begin
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (pop && !empty) begin
                check_readout(o_result);
                readouts++;
            end
            pop <= steady_run || ($urandom_range(0, 99) >= 23);
        end
    end

    // ------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------
    function automatic t_in_item make_item(input t_action act,
                                           input logic [KEY_TOTAL-1:0] pins,
                                           input logic [CODE_W-1:0] code);
        t_in_item it;
        it.action     = act;
        it.pin_levels = pins;
        it.push_code  = code;
        return it;
    endfunction

    // push is left high on return so back-to-back items need no toggle.
    task automatic send_item(input t_in_item it, input bit typed, input t_out_item want);
        t_out_item res;
        while (!steady_run && $urandom_range(0, 99) < 23) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push   <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        res = apply_key_item(it);
        awaited_readouts.push_back(typed ? want : res);
        sent_items++;
    endtask

    task automatic issue(input t_action act, input logic [KEY_TOTAL-1:0] pins);
        send_item(make_item(act, pins, CODE_W'($urandom)), 1'b0, '0);
    endtask

    // Holds off new items until every result is back; the block is then idle.
    task automatic drain();
        push <= 1'b0;
        while (awaited_readouts.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        store_reg(idx, val);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Directed script
    // ------------------------------------------------------------------
    function automatic void add_item(input t_action act, input logic [KEY_TOTAL-1:0] pins,
                                     input logic [CODE_W-1:0] code, input bit typed,
                                     input logic [CODE_W-1:0] want_code,
                                     input logic [KEY_TOTAL-1:0] want_flags);
        t_script_row row;
        row.is_reg             = 1'b0;
        row.idx                = '0;
        row.data               = '0;
        row.item               = make_item(act, pins, code);
        row.typed              = typed;
        row.want.event_code    = want_code;
        row.want.pressed_flags = want_flags;
        script.push_back(row);
    endfunction

    function automatic void add_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] val);
        t_script_row row;
        row.is_reg = 1'b1;
        row.idx    = idx;
        row.data   = val;
        row.item   = '0;
        row.typed  = 1'b0;
        row.want   = '0;
        script.push_back(row);
    endfunction

    function automatic void build_script();
        // FIFO basics on reset settings: empty pop, zero and max codes, clear
        add_item(ACT_POP,   6'h00, 8'h00, 1'b1, 8'h00, '0);
        add_item(ACT_CLEAR, 6'h3F, 8'hFF, 1'b1, 8'h00, '0);
        add_item(ACT_PUSH,  6'h15, 8'h00, 1'b1, 8'h00, '0);
        add_item(ACT_PUSH,  6'h2A, 8'hFF, 1'b1, 8'h00, '0);
        add_item(ACT_POP,   6'h3F, 8'hA5, 1'b1, 8'h00, '0);
        add_item(ACT_POP,   6'h00, 8'h5A, 1'b1, 8'hFF, '0);
        add_item(ACT_POP,   6'h2A, 8'h00, 1'b1, 8'h00, '0);
        add_item(ACT_PUSH,  6'h15, 8'h5A, 1'b1, 8'h00, '0);
        add_item(ACT_CLEAR, 6'h00, 8'h00, 1'b1, 8'h00, '0);
        add_item(ACT_POP,   6'h3F, 8'hFF, 1'b1, 8'h00, '0);
        // zero filter, key 0 long press after one tick, repeat every tick;
        // writes to spare indexes must change nothing
        add_reg(CFG_FILTER_TIME, '0);
        add_reg(CFG_KEY0_TIMING, {16'd1, 8'd1});
        add_reg(CFG_SPARE_LO, '1);
        add_reg(CFG_SPARE_HI, '0);
        // all pins high: key 0 alone active -> press and long press together
        add_item(ACT_SCAN, 6'h3F, 8'h00, 1'b0, '0, '0);
        add_item(ACT_SCAN, 6'h3F, 8'hFF, 1'b0, '0, '0);
        add_item(ACT_SCAN, 6'h3F, 8'h00, 1'b0, '0, '0);
        // timing rewrite while held restarts the repeat count
        add_reg(CFG_KEY0_TIMING, {16'd1, 8'd3});
        add_item(ACT_SCAN, 6'h3F, 8'h00, 1'b0, '0, '0);
        add_item(ACT_SCAN, 6'h3F, 8'h00, 1'b0, '0, '0);
        add_item(ACT_SCAN, 6'h3F, 8'h00, 1'b0, '0, '0);
        // all pins low: five keys active, none down -> release
        add_item(ACT_SCAN, 6'h00, 8'h00, 1'b0, '0, '0);
        add_item(ACT_SCAN, 6'h00, 8'h00, 1'b0, '0, '0);
        repeat (7) add_item(ACT_POP, 6'h00, 8'h00, 1'b0, '0, '0);
    endfunction

    // ------------------------------------------------------------------
    // Random phases
    // ------------------------------------------------------------------
    task automatic set_phase_regs(input int ft, input logic [KEY_TOTAL-1:0] lv,
                                  input bit wide_timing);
        logic [CFG_DATA_W-1:0] data;
        drain();
        // upper data bits are junk the block must drop
        data = CFG_DATA_W'($urandom);
        data[FILTER_W-1:0] = FILTER_W'(ft);
        write_reg(CFG_FILTER_TIME, data);
        data = CFG_DATA_W'($urandom);
        data[KEY_TOTAL-1:0] = lv;
        write_reg(CFG_ACTIVE_LEVELS, data);
        for (int k = 0; k < KEY_TOTAL; k++) begin
            if (wide_timing) begin
                case (k % 4)
                    0:       data = '1;
                    1:       data = '0;
                    2:       data = {16'd1, 8'd1};
                    default: data = CFG_DATA_W'($urandom);
                endcase
            end else begin
                data = {LONG_W'($urandom_range(0, 6)), REP_W'($urandom_range(0, 4))};
            end
            write_reg(CFG_KEY0_TIMING + CFG_IDX_W'(k), data);
        end
        write_reg(CFG_IDX_W'($urandom_range(int'(CFG_SPARE_LO), int'(CFG_SPARE_HI))),
                  CFG_DATA_W'($urandom));
    endtask

    task automatic maybe_pop();
        if ($urandom_range(0, 99) < 20) issue(ACT_POP, KEY_TOTAL'($urandom));
    endtask

    // Mostly clean press/hold/release gestures of one key, mixed with pops,
    // pushes, clears and scans of random pin patterns.
    task automatic run_phase(input int n);
        int                   stop_at;
        int                   k;
        int                   pick;
        int                   bound;
        int                   hold;
        int                   rel;
        logic [KEY_TOTAL-1:0] rest;
        logic [KEY_TOTAL-1:0] down_pins;
        stop_at = sent_items + n;
        while (sent_items < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                k         = $urandom_range(0, KEY_TOTAL - 1);
                rest      = ~levels;
                down_pins = rest ^ (KEY_TOTAL'(1) << k);
                bound     = 2 * int'(filt) + int'(timing[k][TIMING_W-1:REP_W])
                          + 2 * int'(timing[k][REP_W-1:0]) + 4;
                if (bound > 160) bound = 160;
                // one gesture in five is a short bounce
                hold = ($urandom_range(0, 4) == 0) ? $urandom_range(1, bound)
                                                   : $urandom_range(bound / 2, bound);
                repeat (hold) begin
                    issue(ACT_SCAN, ($urandom_range(0, 19) == 0) ? KEY_TOTAL'($urandom)
                                                                 : down_pins);
                    maybe_pop();
                end
                rel = $urandom_range(1, int'(filt) + 3);
                repeat (rel) begin
                    issue(ACT_SCAN, rest);
                    maybe_pop();
                end
            end else if (pick < 70) begin
                repeat ($urandom_range(1, 4)) issue(ACT_POP, KEY_TOTAL'($urandom));
            end else if (pick < 78) begin
                repeat ($urandom_range(1, 3)) issue(ACT_PUSH, KEY_TOTAL'($urandom));
            end else if (pick < 80) begin
                // overrun: wraps the write pointer past unread codes
                repeat (FIFO_DEPTH + 1) issue(ACT_PUSH, KEY_TOTAL'($urandom));
            end else if (pick < 84) begin
                issue(ACT_CLEAR, KEY_TOTAL'($urandom));
            end else begin
                issue(ACT_SCAN, KEY_TOTAL'($urandom));
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        build_script();
        reset_shadow();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (script[i]) begin
            if (script[i].is_reg) begin
                drain();
                write_reg(script[i].idx, script[i].data);
            end else begin
                send_item(script[i].item, script[i].typed, script[i].want);
            end
        end

        set_phase_regs(1, KEY_TOTAL'($urandom), 1'b0);
        run_phase(50);
        set_phase_regs(3, '0, 1'b0);
        run_phase(50);
        // zero filter, all levels high, no idling on either side
        steady_run = 1'b1;
        set_phase_regs(0, '1, 1'b0);
        run_phase(50);
        drain();
        steady_run = 1'b0;
        set_phase_regs(2, KEY_TOTAL'($urandom), 1'b1);
        run_phase(50);
        set_phase_regs($urandom_range(1, 6), KEY_TOTAL'($urandom), 1'b0);
        run_phase(50);
        set_phase_regs($urandom_range(1, 6), KEY_TOTAL'($urandom), 1'b0);
        run_phase(50);
        // widest filter: presses need well over a hundred ticks
        set_phase_regs(127, KEY_TOTAL'($urandom), 1'b0);
        run_phase(120);

        drain();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
